// ----- hdl/bcd_pkg.sv -----
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types, format codes and fixed-point helpers for the BC1..BC5 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bcd_pkg;

   typedef enum logic [2:0] {
      FMT_BC1 = 3'd0,
      FMT_BC2 = 3'd1,
      FMT_BC3 = 3'd2,
      FMT_BC4 = 3'd3,
      FMT_BC5 = 3'd4
   } fmt_type;

   localparam int unsigned LANES = 4;

   // per-block palettes, RGBA colour entries plus two 8-level channel tables
   typedef struct packed {
      logic [3:0][31:0] colour;
      logic [7:0][7:0]  lo_level;
      logic [7:0][7:0]  hi_level;
   } pal_type;

   // selector codes for one texel
   typedef struct packed {
      logic [1:0] colour_code;
      logic [3:0] alpha4;
      logic [2:0] lo_code;
      logic [2:0] hi_code;
   } lane_code_type;

   // v * 255 / 31, truncated
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [12:0] x;
      logic [28:0] p;
      x = 13'(v) * 13'd255;
      p = 29'(x) * 29'd33826;
      return p[27:20];
   endfunction

   // v * 255 / 63, truncated
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [13:0] x;
      logic [28:0] p;
      x = 14'(v) * 14'd255;
      p = 29'(x) * 29'd16645;
      return p[27:20];
   endfunction

   // x / 3 for x <= 765
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [19:0] p;
      p = 20'(x) * 20'd683;
      return p[18:11];
   endfunction

   // x / 7 for x <= 1785
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [21:0] p;
      p = 22'(x) * 22'd2341;
      return p[21:14];
   endfunction

   // x / 5 for x <= 1275
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [21:0] p;
      p = 22'(x) * 22'd3277;
      return p[21:14];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/bc1_to_bc5_block_decoder_top.sv -----
// ----------------------------------------------------------------------------
// bc1_to_bc5_block_decoder_top
// BC1..BC5 4x4 texture block decoder, one RGBA8 row per transaction.
// ----------------------------------------------------------------------------
// Each accepted block produces four row transactions, top row first, with
// tlast on the fourth. The output row register is the limit: one row leaves
// per cycle while the output is not stalled, and a new block is taken once
// the previous block's fourth row is loaded. Data pass the input register,
// the palette register and the row register in turn. Four lanes decode the four
// columns of a row in parallel. Write block_format only while idle.
`default_nettype none

module bc1_to_bc5_block_decoder_top
   import bcd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,   // block_low[63:0], block_high[127:64]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [135:0]       rsp_tdata,   // row_index[1:0], texel_0..3 [129:2], pad
   output logic               rsp_tlast,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_data     // block_format
);

   fmt_type fmt_ff, fmt_in;

   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] s1_lo_ff, s1_lo_in;
   logic [63:0] s1_hi_ff, s1_hi_in;

   logic               s2_valid_ff, s2_valid_in;
   logic [1:0]         s2_row_ff, s2_row_in;
   pal_type            s2_pal_ff, s2_pal_in;
   logic [15:0][1:0]   s2_ccode_ff, s2_ccode_in;
   logic [15:0][3:0]   s2_acode_ff, s2_acode_in;
   logic [15:0][2:0]   s2_lcode_ff, s2_lcode_in;
   logic [15:0][2:0]   s2_hcode_ff, s2_hcode_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_row_ff, rsp_row_in;
   logic [LANES-1:0][31:0] rsp_texel_ff, rsp_texel_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic        req_acc;
   logic        out_load;
   logic        s2_done;
   logic        s1_move;
   logic [63:0] colour_blk;
   pal_type     pal_next;

   lane_code_type [LANES-1:0] lane_code;
   logic [LANES-1:0][31:0]    lane_texel;

   // handshake control
   assign out_load   = s2_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign s2_done    = out_load && (s2_row_ff == 2'd3);
   assign s1_move    = s1_valid_ff && (!s2_valid_ff || s2_done);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign fmt_in = (csr_valid && csr_ready) ? fmt_type'(csr_data) : fmt_ff;

   assign s1_valid_in = req_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign s1_lo_in    = req_acc ? req_tdata[63:0]   : s1_lo_ff;
   assign s1_hi_in    = req_acc ? req_tdata[127:64] : s1_hi_ff;

   assign colour_blk = (fmt_ff == FMT_BC1) ? s1_lo_ff : s1_hi_ff;

   bcd_palette u_palette (
      .colour_ep (colour_blk[31:0]),
      .lo_ep     (s1_lo_ff[15:0]),
      .hi_ep     (s1_hi_ff[15:0]),
      .pal       (pal_next)
   );

   always_comb begin
      s2_valid_in = s1_move ? 1'b1 : (s2_done ? 1'b0 : s2_valid_ff);
      if (s1_move) begin
         s2_row_in = 2'd0;
      end else if (out_load) begin
         s2_row_in = s2_row_ff + 2'd1;
      end else begin
         s2_row_in = s2_row_ff;
      end
      s2_pal_in   = s1_move ? pal_next           : s2_pal_ff;
      s2_ccode_in = s1_move ? colour_blk[63:32]  : s2_ccode_ff;
      s2_acode_in = s1_move ? s1_lo_ff           : s2_acode_ff;
      s2_lcode_in = s1_move ? s1_lo_ff[63:16]    : s2_lcode_ff;
      s2_hcode_in = s1_move ? s1_hi_ff[63:16]    : s2_hcode_ff;
   end

   always_comb begin
      logic [3:0] tex_idx;
      for (int c = 0; c < LANES; c++) begin
         tex_idx                  = {s2_row_ff, 2'(c)};
         lane_code[c].colour_code = s2_ccode_ff[tex_idx];
         lane_code[c].alpha4      = s2_acode_ff[tex_idx];
         lane_code[c].lo_code     = s2_lcode_ff[tex_idx];
         lane_code[c].hi_code     = s2_hcode_ff[tex_idx];
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      bcd_lane u_lane (
         .fmt   (fmt_ff),
         .pal   (s2_pal_ff),
         .code  (lane_code[g]),
         .texel (lane_texel[g])
      );
   end

   // row merge / output register
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_row_in   = out_load ? s2_row_ff : rsp_row_ff;
   assign rsp_texel_in = out_load ? lane_texel : rsp_texel_ff;
   assign rsp_last_in  = out_load ? (s2_row_ff == 2'd3) : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_BC1;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_row_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s2_row_ff    <= s2_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_lo_ff     <= s1_lo_in;
      s1_hi_ff     <= s1_hi_in;
      s2_pal_ff    <= s2_pal_in;
      s2_ccode_ff  <= s2_ccode_in;
      s2_acode_ff  <= s2_acode_in;
      s2_lcode_ff  <= s2_lcode_in;
      s2_hcode_ff  <= s2_hcode_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_texel_ff <= rsp_texel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_texel_ff[3], rsp_texel_ff[2], rsp_texel_ff[1],
                        rsp_texel_ff[0], rsp_row_ff};

endmodule

`default_nettype wire

// ----- hdl/bcd_palette.sv -----
// ----------------------------------------------------------------------------
// bcd_palette
// Builds the four-entry colour palette and both 8-level channel palettes.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_palette
   import bcd_pkg::*;
(
   input  wire logic [31:0] colour_ep,
   input  wire logic [15:0] lo_ep,
   input  wire logic [15:0] hi_ep,
   output pal_type          pal
);

   function automatic logic [7:0][7:0] chan_levels(input logic [15:0] ep);
      logic [7:0][7:0] lvl;
      logic [7:0]      e0;
      logic [7:0]      e1;
      logic [10:0]     sum;
      e0 = ep[7:0];
      e1 = ep[15:8];
      lvl[0] = e0;
      lvl[1] = e1;
      for (int k = 2; k < 8; k++) begin
         if (e0 > e1) begin
            sum    = 11'(8 - k) * 11'(e0) + 11'(k - 1) * 11'(e1);
            lvl[k] = div7(sum);
         end else if (k == 6) begin
            sum    = '0;
            lvl[k] = 8'h00;
         end else if (k == 7) begin
            sum    = '0;
            lvl[k] = 8'hFF;
         end else begin
            sum    = 11'(6 - k) * 11'(e0) + 11'(k - 1) * 11'(e1);
            lvl[k] = div5(sum);
         end
      end
      return lvl;
   endfunction

   logic [15:0] c0;
   logic [15:0] c1;
   logic [2:0][7:0] e0;   // b, g, r
   logic [2:0][7:0] e1;
   logic [2:0][7:0] mix2;
   logic [2:0][7:0] mix3;
   logic [8:0]      half;

   assign c0 = colour_ep[15:0];
   assign c1 = colour_ep[31:16];

   always_comb begin
      e0[2] = expand5(c0[15:11]);
      e0[1] = expand6(c0[10:5]);
      e0[0] = expand5(c0[4:0]);
      e1[2] = expand5(c1[15:11]);
      e1[1] = expand6(c1[10:5]);
      e1[0] = expand5(c1[4:0]);
      half  = '0;
      for (int ch = 0; ch < 3; ch++) begin
         if (c0 > c1) begin
            mix2[ch] = div3({1'b0, e0[ch], 1'b0} + 10'(e1[ch]));
            mix3[ch] = div3(10'(e0[ch]) + {1'b0, e1[ch], 1'b0});
         end else begin
            half     = 9'(e0[ch]) + 9'(e1[ch]);
            mix2[ch] = half[8:1];
            mix3[ch] = 8'h00;
         end
      end
      pal.colour[0] = {8'hFF, e0[0], e0[1], e0[2]};
      pal.colour[1] = {8'hFF, e1[0], e1[1], e1[2]};
      pal.colour[2] = {8'hFF, mix2[0], mix2[1], mix2[2]};
      pal.colour[3] = (c0 > c1) ? {8'hFF, mix3[0], mix3[1], mix3[2]} : 32'h0;
      pal.lo_level  = chan_levels(lo_ep);
      pal.hi_level  = chan_levels(hi_ep);
   end

endmodule

`default_nettype wire

// ----- hdl/bcd_lane.sv -----
// ----------------------------------------------------------------------------
// bcd_lane
// Decodes one texel of the current row from the block palettes.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_lane
   import bcd_pkg::*;
(
   input  wire fmt_type          fmt,
   input  wire pal_type          pal,
   input  wire lane_code_type    code,
   output logic [31:0]           texel
);

   logic [31:0] rgb;
   logic [7:0]  lo_v;
   logic [7:0]  hi_v;

   assign rgb  = pal.colour[code.colour_code];
   assign lo_v = pal.lo_level[code.lo_code];
   assign hi_v = pal.hi_level[code.hi_code];

   always_comb begin
      case (fmt)
         FMT_BC1: texel = rgb;
         FMT_BC2: texel = {code.alpha4, code.alpha4, rgb[23:0]};  // a * 17
         FMT_BC3: texel = {lo_v, rgb[23:0]};
         FMT_BC4: texel = {8'hFF, lo_v, lo_v, lo_v};
         FMT_BC5: texel = {8'hFF, 8'h00, hi_v, lo_v};
         default: texel = 32'h0;
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/bcd_checker.sv -----
// ----------------------------------------------------------------------------
// bcd_checker
// Port-level checks for the block decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [135:0]  rsp_tdata,
   input wire logic          rsp_tlast
);

   a_last_on_row3: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[1:0] == 2'd3)))
      else $error("tlast does not match row 3");

   a_rows_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && (rsp_tdata[1:0] == 2'($past(rsp_tdata[1:0]) + 2'd1))))
      else $error("row sequence broken inside a block");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind bc1_to_bc5_block_decoder_top bcd_checker u_checker (.*);

`default_nettype wire
